>>> hw/rtl/periodic_frame_tx_scheduler_macros.svh
// Assertion macros shared by the periodic frame scheduler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_FRAME_TX_SCHEDULER_MACROS_SVH
`define PERIODIC_FRAME_TX_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that holds on every clock edge outside reset
`define PFTS_CHK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfts check failed");

// Check that also holds while reset is asserted
`define PFTS_CHK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pfts check failed");

`else

`define PFTS_CHK(label, clk, rst, prop)
`define PFTS_CHK_ALWAYS(label, clk, prop)

`endif

`endif

>>> hw/rtl/pfts_pkg.sv
// Shared types, codes and helper functions for the periodic frame scheduler.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package pfts_pkg;

  // Default table depth and per-tick frame limit
  localparam int SLOTS_DEF = 16;
  localparam int RES_MAX   = 16;
  localparam int FCNT_W    = $clog2(RES_MAX + 1);

  // Input actions
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_TICK = 2'd2
  } act_t;

  // Status codes in a reply word
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } resp_code_t;

  // Result word kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input word
    logic rd;       // read slot memories at the walk index
    logic ev;       // evaluate the slot last read, advance index
    logic commit;   // finish add or delete
    logic reply;    // load the status word into the output register
    logic flush;    // load the held frame as the final word
  } pfts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_t in_op;      // action on the input port
    logic in_id_ok;   // identifier on the input port is legal
    logic op_tick;    // captured word is a tick
    logic idx_last;   // walk index is at the last slot
    logic ev_hold;    // evaluation must wait for the output register
    logic out_free;   // output register can load this cycle
    logic pend_valid; // a frame is held for the output
  } pfts_stat_t;

  // Legal identifiers: 0x000..0x07F and 0x180..0x4FF minus the four reserved
  function automatic logic id_ok(input logic [10:0] id);
    logic ok;
    ok = 1'b0;
    if (id <= 11'h07F) begin
      ok = 1'b1;
    end else if (id >= 11'h180 && id <= 11'h4FF) begin
      ok = !(id == 11'h180 || id == 11'h280 || id == 11'h380 || id == 11'h480);
    end
    return ok;
  endfunction

  // Left-align the low len bytes of the payload; len of zero gives zero
  function automatic logic [63:0] frame_pack(input logic [63:0] data, input logic [3:0] len);
    logic [6:0] sh;
    sh = {(4'd8 - len), 3'b000};
    return data << sh;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pfts_ctrl.sv
// Sequencing state machine for the periodic frame scheduler.
// Depends on pfts_pkg and the assertion macro header.
`default_nettype none
`include "periodic_frame_tx_scheduler_macros.svh"

module pfts_ctrl import pfts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  pfts_stat_t st,
  output pfts_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_EVAL   = 6'b000100,
    S_COMMIT = 6'b001000,
    S_REPLY  = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (st.in_op) inside
            ACT_ADD, ACT_DEL: state_next = st.in_id_ok ? S_READ : S_REPLY;
            ACT_TICK:         state_next = S_READ;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!st.ev_hold) begin
          cmd.ev = 1'b1;
          if (st.idx_last) begin
            state_next = st.op_tick ? S_FLUSH : S_COMMIT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.reply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Input is taken only between items
  assign in_stall = (state != S_IDLE);

  // A status reply never overtakes a held frame
  `PFTS_CHK(a_reply_no_pend, clk, rst, (state == S_REPLY) |-> !st.pend_valid)
  // Only a tick walk waits on the output register
  `PFTS_CHK(a_hold_only_tick, clk, rst, (state == S_EVAL && st.ev_hold) |-> st.op_tick)
  // The walk always ends with the last slot evaluated
  `PFTS_CHK(a_walk_end, clk, rst, (state == S_COMMIT) |-> $past(cmd.ev && st.idx_last))

endmodule

`default_nettype wire

>>> hw/rtl/pfts_datapath.sv
// Slot memories, valid bits, walk index, frame holding register and output register.
// Depends on pfts_pkg and the assertion macro header.
`default_nettype none
`include "periodic_frame_tx_scheduler_macros.svh"

module pfts_datapath import pfts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  pfts_cmd_t   cmd,
  output pfts_stat_t  st,
  input  logic [1:0]  action,
  input  logic [10:0] can_id,
  input  logic [31:0] period_ms,
  input  logic [7:0]  length,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [10:0] frame_id,
  output logic [3:0]  frame_length,
  output logic [63:0] frame_data,
  output logic        last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Slot memories; contents are meaningful only where slot_valid is set
  logic [10:0] mem_ident   [SLOTS];
  logic [3:0]  mem_len     [SLOTS];
  logic [63:0] mem_payload [SLOTS];
  logic [31:0] mem_period  [SLOTS];
  logic [31:0] mem_count   [SLOTS];
  logic [SLOTS-1:0] slot_valid;

  // Captured word
  act_t        cur_op;
  logic [10:0] cur_id;
  logic [31:0] cur_period;
  logic [3:0]  cur_len;
  logic [63:0] cur_payload;

  // Walk state
  logic [IDX_W-1:0] idx;
  logic [10:0]      rd_ident;
  logic [3:0]       rd_len;
  logic [63:0]      rd_payload;
  logic [31:0]      rd_period;
  logic [31:0]      rd_count;

  // Search results
  logic             match_found, free_found;
  logic [IDX_W-1:0] match_idx, free_idx;
  resp_code_t       reply_status;

  // Held frame and per-tick count
  logic              pend_valid;
  logic [10:0]       pend_id;
  logic [3:0]        pend_len;
  logic [63:0]       pend_data;
  logic [FCNT_W-1:0] frame_cnt;

  logic             is_tick, slot_on, active, due, cap_ok, need_push, out_free;
  logic [31:0]      cnt_dec;
  logic             hit, add_ok;
  logic [IDX_W-1:0] tgt;
  logic             load_status, load_frame;
  logic             frame_last;

  // Per-slot evaluation
  assign is_tick   = (cur_op == ACT_TICK);
  assign slot_on   = slot_valid[idx];
  assign active    = slot_on && (rd_period != 32'd0);
  assign cnt_dec   = rd_count - 32'd1;
  assign due       = active && (cnt_dec == 32'd0);
  assign cap_ok    = (frame_cnt < FCNT_W'(RES_MAX));
  assign need_push = is_tick && due && cap_ok && pend_valid;
  assign out_free  = !out_valid || !out_stall;
  assign hit       = slot_on && (rd_ident == cur_id);

  // Add target: lowest of first free slot and the slot being replaced
  always_comb begin
    add_ok = 1'b1;
    tgt    = free_idx;
    if (match_found) begin
      tgt = (free_found && (free_idx < match_idx)) ? free_idx : match_idx;
    end else if (!free_found) begin
      add_ok = 1'b0;
    end
  end

  // Status to controller
  always_comb begin
    st.in_op      = act_t'(action);
    st.in_id_ok   = id_ok(can_id);
    st.op_tick    = is_tick;
    st.idx_last   = (idx == IDX_W'(SLOTS - 1));
    st.ev_hold    = need_push && !out_free;
    st.out_free   = out_free;
    st.pend_valid = pend_valid;
  end

  // Captured word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op      <= act_t'(action);
      cur_id      <= can_id;
      cur_period  <= period_ms;
      cur_len     <= (length > 8'd8) ? 4'd8 : length[3:0];
      cur_payload <= payload;
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.ev) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_ident   <= mem_ident[idx];
      rd_len     <= mem_len[idx];
      rd_payload <= mem_payload[idx];
      rd_period  <= mem_period[idx];
      rd_count   <= mem_count[idx];
    end
  end

  // Memory write port: countdown update on tick, whole slot on add
  always_ff @(posedge clk) begin
    if (cmd.ev && is_tick && active) begin
      mem_count[idx] <= due ? rd_period : cnt_dec;
    end else if (cmd.commit && cur_op == ACT_ADD && add_ok) begin
      mem_ident[tgt]   <= cur_id;
      mem_len[tgt]     <= cur_len;
      mem_payload[tgt] <= cur_payload;
      mem_period[tgt]  <= cur_period;
      mem_count[tgt]   <= cur_period;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit) begin
      if (match_found) begin
        slot_valid[match_idx] <= 1'b0;
      end
      if (cur_op == ACT_ADD && add_ok) begin
        slot_valid[tgt] <= 1'b1;
      end
    end
  end

  // Identifier search for add and delete
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.capture) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.ev && !is_tick) begin
      if (hit && !match_found) begin
        match_found <= 1'b1;
      end
      if (!slot_on && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev && !is_tick) begin
      if (hit && !match_found) begin
        match_idx <= idx;
      end
      if (!slot_on && !free_found) begin
        free_idx <= idx;
      end
    end
  end

  // Reply status
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reply_status <= id_ok(can_id) ? ST_OK : ST_BAD_ID;
    end else if (cmd.commit && cur_op == ACT_ADD && !add_ok) begin
      reply_status <= ST_FULL;
    end
  end

  // Held frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      frame_cnt  <= '0;
    end else if (cmd.capture) begin
      pend_valid <= 1'b0;
      frame_cnt  <= '0;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end else if (cmd.ev && is_tick && due && cap_ok) begin
      pend_valid <= 1'b1;
      frame_cnt  <= frame_cnt + FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev && is_tick && due && cap_ok) begin
      pend_id   <= rd_ident;
      pend_len  <= rd_len;
      pend_data <= frame_pack(rd_payload, rd_len);
    end
  end

  // Output register
  assign load_status = cmd.reply;
  assign load_frame  = cmd.flush || (cmd.ev && need_push);
  assign frame_last  = cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_status || load_frame) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      kind         <= KIND_STATUS;
      status       <= reply_status;
      frame_id     <= '0;
      frame_length <= '0;
      frame_data   <= '0;
      last         <= 1'b1;
    end else if (load_frame) begin
      kind         <= KIND_FRAME;
      status       <= ST_OK;
      frame_id     <= pend_id;
      frame_length <= pend_len;
      frame_data   <= pend_data;
      last         <= frame_last;
    end
  end

  // Frames per tick never exceed the limit
  `PFTS_CHK(a_frame_cap, clk, rst, frame_cnt <= FCNT_W'(RES_MAX))
  // Output loads only into a free register
  `PFTS_CHK(a_load_free, clk, rst, (load_status || load_frame) |-> out_free)
  // A status word is always the final word of its item
  `PFTS_CHK(a_status_last, clk, rst, (out_valid && kind == KIND_STATUS) |-> last)

endmodule

`default_nettype wire

>>> hw/rtl/periodic_frame_tx_scheduler.sv
// Periodic transmit slot table: add, delete and millisecond tick handling.
// Channels: input word (action, can_id, period_ms, length, payload) on in_valid/in_stall;
// result word (kind, status, frame_id, frame_length, frame_data, last) on out_valid/out_stall.
// Add and delete each give one status word with last set. A tick gives one frame word per
// slot whose countdown expires (at most 16, slot order), last set on the final one; a tick
// with nothing due gives no word.
// Every tick, and every add or delete with a legal identifier, walks the whole table through
// the single read port of the slot memory: each slot is read, then evaluated.
// in_stall stays high through the walk and the commit and reply states of add or delete, or
// through the walk and the flush state of a tick, plus output waits; the status word of add
// or delete is loaded in the reply state after the commit, and the next item is accepted in idle.
// A rejected identifier skips the walk and loads its status word from the reply state.
// Frames of a tick leave as the walk goes on; a stalled receiver holds the walk at the next
// due slot. Reset clears the valid bits and the control state; the slot memories need no
// clearing pass, an empty table is ready in the first cycle after reset.
// Depends on pfts_pkg, pfts_ctrl and pfts_datapath.
`default_nettype none

module periodic_frame_tx_scheduler import pfts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [10:0] can_id,
  input  logic [31:0] period_ms,
  input  logic [7:0]  length,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [10:0] frame_id,
  output logic [3:0]  frame_length,
  output logic [63:0] frame_data,
  output logic        last
);

  pfts_cmd_t  cmd;
  pfts_stat_t st;

  // Sequencer
  pfts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Slot table and result path
  pfts_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (action),
    .can_id       (can_id),
    .period_ms    (period_ms),
    .length       (length),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .frame_data   (frame_data),
    .last         (last)
  );

endmodule

`default_nettype wire
